// File: rtl/core/irpw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants of the IR pulse width packet receiver.
// ----------------------------------------------------------------------------
package irpw_pkg;

  localparam int unsigned TIME_W      = 16;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned ID_W        = 7;
  localparam int unsigned ID_LSB      = 6;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned PACKET_BITS = 13;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef logic [TIME_W-1:0] time_us_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RECEIVE_ENABLE = 3'd0,
    REG_HEADER_MIN     = 3'd1,
    REG_HEADER_MAX     = 3'd2,
    REG_ONE_MIN        = 3'd3,
    REG_ONE_MAX        = 3'd4,
    REG_ZERO_MIN       = 3'd5,
    REG_ZERO_MAX       = 3'd6
  } cfg_reg_t;

  localparam time_us_t HEADER_MIN_RST = 16'd2100;
  localparam time_us_t HEADER_MAX_RST = 16'd2700;
  localparam time_us_t ONE_MIN_RST    = 16'd1000;
  localparam time_us_t ONE_MAX_RST    = 16'd1400;
  localparam time_us_t ZERO_MIN_RST   = 16'd400;
  localparam time_us_t ZERO_MAX_RST   = 16'd800;

  typedef struct packed {
    logic     receive_enable;
    time_us_t header_min_us;
    time_us_t header_max_us;
    time_us_t one_min_us;
    time_us_t one_max_us;
    time_us_t zero_min_us;
    time_us_t zero_max_us;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] packet_word;
    logic [ID_W-1:0]   sender_id;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/irpw_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irpw channel interfaces
// Valid/ready channels for capture events and decoded packets.
// ----------------------------------------------------------------------------
interface irpw_capture_if;
  logic             valid;
  logic             ready;
  irpw_pkg::time_us_t fall_time;
  irpw_pkg::time_us_t rise_time;

  modport source (output valid, output fall_time, output rise_time, input ready);
  modport sink   (input valid, input fall_time, input rise_time, output ready);
endinterface

interface irpw_packet_if;
  logic                              valid;
  logic                              ready;
  logic [irpw_pkg::WORD_W-1:0]       packet_word;
  logic [irpw_pkg::ID_W-1:0]         sender_id;

  modport source (output valid, output packet_word, output sender_id, input ready);
  modport sink   (input valid, input packet_word, input sender_id, output ready);
endinterface
`default_nettype wire

// File: rtl/core/irpw_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irpw_cfg_regs
// Configuration register file: enable and the three width windows.
// ----------------------------------------------------------------------------
module irpw_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             write_enable,
  input  wire logic [irpw_pkg::CFG_INDEX_W-1:0] index,
  input  wire logic [irpw_pkg::CFG_DATA_W-1:0]  data,
  output irpw_pkg::cfg_t                        cfg
);

  irpw_pkg::cfg_t regs;

  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.receive_enable <= 1'b0;
      regs.header_min_us  <= irpw_pkg::HEADER_MIN_RST;
      regs.header_max_us  <= irpw_pkg::HEADER_MAX_RST;
      regs.one_min_us     <= irpw_pkg::ONE_MIN_RST;
      regs.one_max_us     <= irpw_pkg::ONE_MAX_RST;
      regs.zero_min_us    <= irpw_pkg::ZERO_MIN_RST;
      regs.zero_max_us    <= irpw_pkg::ZERO_MAX_RST;
    end else if (write_enable) begin
      unique case (index)
        irpw_pkg::REG_RECEIVE_ENABLE: regs.receive_enable <= data[0];
        irpw_pkg::REG_HEADER_MIN:     regs.header_min_us  <= data;
        irpw_pkg::REG_HEADER_MAX:     regs.header_max_us  <= data;
        irpw_pkg::REG_ONE_MIN:        regs.one_min_us     <= data;
        irpw_pkg::REG_ONE_MAX:        regs.one_max_us     <= data;
        irpw_pkg::REG_ZERO_MIN:       regs.zero_min_us    <= data;
        irpw_pkg::REG_ZERO_MAX:       regs.zero_max_us    <= data;
        default: ; // unmapped index, dropped
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/irpw_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irpw_decoder
// Pulse width, window classification and the packet shift/count state.
// ----------------------------------------------------------------------------
module irpw_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire irpw_pkg::time_us_t fall_time,
  input  wire irpw_pkg::time_us_t rise_time,
  input  wire irpw_pkg::cfg_t     cfg,
  output irpw_pkg::result_t       result
);

  localparam logic [irpw_pkg::COUNT_W-1:0] COUNT_LAST =
    irpw_pkg::COUNT_W'(irpw_pkg::PACKET_BITS);
  localparam logic [irpw_pkg::COUNT_W-1:0] COUNT_DONE =
    irpw_pkg::COUNT_W'(irpw_pkg::PACKET_BITS + 1);
  localparam logic [irpw_pkg::COUNT_W-1:0] COUNT_ONE =
    irpw_pkg::COUNT_W'(1);

  function automatic logic in_window(irpw_pkg::time_us_t w, irpw_pkg::time_us_t lo,
                                     irpw_pkg::time_us_t hi);
    return (w >= lo) && (w <= hi);
  endfunction

  logic [irpw_pkg::WORD_W-1:0]  shift_word, shift_word_next;
  logic [irpw_pkg::COUNT_W-1:0] bit_count, bit_count_next;

  irpw_pkg::time_us_t           width;
  logic                         hdr_hit, one_hit, zero_hit, active;
  logic [irpw_pkg::WORD_W-1:0]  shifted;
  logic [irpw_pkg::COUNT_W-1:0] count_inc;

  // wrap case follows the capture timer convention: (0xFFFF - fall) + rise
  always_comb begin
    if (rise_time >= fall_time) begin
      width = rise_time - fall_time;
    end else begin
      width = (16'hFFFF - fall_time) + rise_time;
    end
  end

  assign hdr_hit   = in_window(width, cfg.header_min_us, cfg.header_max_us);
  assign one_hit   = in_window(width, cfg.one_min_us, cfg.one_max_us);
  assign zero_hit  = in_window(width, cfg.zero_min_us, cfg.zero_max_us);
  assign active    = (bit_count >= COUNT_ONE) && (bit_count <= COUNT_LAST);
  assign shifted   = {shift_word[irpw_pkg::WORD_W-2:0], one_hit};
  assign count_inc = bit_count + COUNT_ONE;

  always_comb begin
    shift_word_next    = shift_word;
    bit_count_next     = bit_count;
    result.valid       = 1'b0;
    result.packet_word = shifted;
    result.sender_id   = shifted[irpw_pkg::ID_LSB +: irpw_pkg::ID_W];
    priority if (!cfg.receive_enable) begin
      // ignored
    end else if (hdr_hit) begin
      shift_word_next = '0;
      bit_count_next  = COUNT_ONE;
    end else if (!active) begin
      // idle, not a header
    end else if (!one_hit && !zero_hit) begin
      shift_word_next = '0;
      bit_count_next  = '0;
    end else if (count_inc == COUNT_DONE) begin
      result.valid    = 1'b1;
      shift_word_next = '0;
      bit_count_next  = '0;
    end else begin
      shift_word_next = shifted;
      bit_count_next  = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word <= '0;
      bit_count  <= '0;
    end else if (advance) begin
      shift_word <= shift_word_next;
      bit_count  <= bit_count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ir_pulse_width_packet_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_width_packet_receiver_unit
// Decodes pulse-width coded IR packets from captured mark timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   capture : one request per IR mark, fall_time/rise_time in microseconds
//             of a free-running 16-bit timer.
//   packet  : one request per completed packet: packet_word (first bit MSB,
//             right aligned) and sender_id (packet_word bits 12..6).
//   cfg_*   : plain write port, register index 0..6 (enable, header/one/zero
//             min/max). Write only while no capture is in flight.
// Path: the capture register holds a capture for decoding; a finished packet
//   is loaded into the result register, which drives packet.valid.
// Throughput: one capture per cycle unless a result waits on packet.ready,
//   set by the single decode stage between capture and result register.
// Stall: while a result waits on packet.ready the decode stage holds; an empty
//   capture register still takes one more request, then capture.ready drops.
// Reset (rst, synchronous): receiver idle, packet state cleared, enable off,
//   windows at 2100-2700 / 1000-1400 / 400-800 us.
// ----------------------------------------------------------------------------
module ir_pulse_width_packet_receiver_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  irpw_capture_if.sink                          capture,
  irpw_packet_if.source                         packet,
  input  wire logic                             cfg_write_enable,
  input  wire logic [irpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [irpw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  irpw_pkg::cfg_t     cfg;
  irpw_pkg::result_t  dec_result;

  // capture register
  logic               cap_valid;
  irpw_pkg::time_us_t cap_fall;
  irpw_pkg::time_us_t cap_rise;

  // result register
  logic                          res_valid;
  logic [irpw_pkg::WORD_W-1:0]   res_word;
  logic [irpw_pkg::ID_W-1:0]     res_id;

  logic advance;
  logic load;

  // decode only when the result register is free or being emptied
  assign advance       = cap_valid && (!res_valid || packet.ready);
  assign capture.ready = !cap_valid || advance;
  assign load          = capture.valid && capture.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (load) begin
      cap_valid <= 1'b1;
    end else if (advance) begin
      cap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cap_fall <= capture.fall_time;
      cap_rise <= capture.rise_time;
    end
  end

  irpw_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (cfg_write_enable),
    .index        (cfg_index),
    .data         (cfg_data),
    .cfg          (cfg)
  );

  irpw_decoder u_dec (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .fall_time (cap_fall),
    .rise_time (cap_rise),
    .cfg       (cfg),
    .result    (dec_result)
  );

  // result register: a decode step always overwrites its valid flag (free or emptied)
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= dec_result.valid;
    end else if (packet.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec_result.valid) begin
      res_word <= dec_result.packet_word;
      res_id   <= dec_result.sender_id;
    end
  end

  assign packet.valid       = res_valid;
  assign packet.packet_word = res_word;
  assign packet.sender_id   = res_id;

endmodule
`default_nettype wire

// File: tb/ir_pulse_width_packet_receiver_unit_tb.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_packet_receiver_unit_tb
// Self-checking bench for the IR pulse width packet receiver. A directed
// table comes first: the disabled receiver, boundary and wrapped widths,
// aborts, a header restart and one packet with its expected word typed in.
// Random marks follow, mostly well-formed packets under several window
// settings. Every accepted capture runs through a local decoder, and each
// packet request is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ir_pulse_width_packet_receiver_unit_tb;

  localparam int unsigned        CYCLE_LIMIT   = 300000;
  localparam int unsigned        SETTLE_CYCLES = 4;     // capture reg + decode stage, with margin
  localparam int unsigned        END_CYCLES    = 10;
  localparam int unsigned        HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned        PHASE_MARKS   = 130;
  localparam int unsigned        SHORT_MARKS   = 30;    // settings that can yield no packet
  localparam int unsigned        MAX_REPORTS   = 10;
  localparam int                 NUM_SETTINGS  = 6;
  localparam irpw_pkg::time_us_t TIMER_MAX     = '1;

  // What a random mark is aimed at
  typedef enum {MK_HEADER, MK_ONE, MK_ZERO, MK_NOISE} mark_kind_t;

  // Window settings visited by the random part
  typedef enum {
    SET_DEFAULT, SET_RANDOM, SET_EXTREME, SET_EMPTY_ZERO, SET_ALL_HEADER, SET_DISABLED
  } setting_t;

  typedef struct packed {
    logic [irpw_pkg::WORD_W-1:0] word;
    logic [irpw_pkg::ID_W-1:0]   id;
  } packet_t;

  // One line of the directed table: either a register write or a mark.
  // pinned marks carry a hand-computed packet.
  typedef struct {
    bit                          is_cfg;
    irpw_pkg::cfg_reg_t          reg_idx;
    irpw_pkg::time_us_t          reg_val;
    irpw_pkg::time_us_t          fall_t;
    irpw_pkg::time_us_t          rise_t;
    bit                          pinned;
    logic [irpw_pkg::WORD_W-1:0] word;
    logic [irpw_pkg::ID_W-1:0]   id;
  } dir_row_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write_enable;
  logic [irpw_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [irpw_pkg::CFG_DATA_W-1:0]  cfg_data;

  irpw_capture_if cap_if ();
  irpw_packet_if  pkt_if ();

  ir_pulse_width_packet_receiver_unit dut (
    .clk              (clk),
    .rst              (rst),
    .capture          (cap_if),
    .packet           (pkt_if),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decoder state and its copy of the registers
  irpw_pkg::cfg_t               shadow_cfg;
  logic [irpw_pkg::WORD_W-1:0]  rx_word;
  logic [irpw_pkg::COUNT_W-1:0] rx_count;     // 0 idle, k>0: k-1 bits taken since the header
  packet_t                      expected_packets[$];

  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned marks_sent    = 0;
  int unsigned tx_idle_pct   = 6;
  int unsigned rx_idle_pct   = 48;
  int unsigned hold_requests = 0;   // bumped by stimulus, served by the receiver
  int unsigned holds_taken   = 0;
  int unsigned hold_left     = 0;
  bit          pin_valid;
  packet_t     pin_packet;

  // Directed table. Reset windows: header 2100-2700, one 1000-1400,
  // zero 400-800. The packet at the end is 1010011010110 -> word 0x14d6,
  // id bits 12..6 = 0x53.
  dir_row_t dir_rows [25] = '{
    // receiver still disabled after reset: both ignored
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'hffff, 16'h0000, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h03e8, 16'h0d48, 1'b0, 16'h0000, 7'h00},
    '{1'b1, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000, 7'h00},
    // idle, not a header: widest and zero width
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'hffff, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'hffff, 16'hffff, 1'b0, 16'h0000, 7'h00},
    // header at its upper bound, a one, then a bad width aborts
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h0a8c, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h04b0, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h0064, 1'b0, 16'h0000, 7'h00},
    // one width while idle: ignored
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h03e8, 1'b0, 16'h0000, 7'h00},
    // wrapped header, a zero, then a header at its lower bound restarts
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'hfb4f, 16'h04b0, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h0258, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h1388, 16'h1bbc, 1'b0, 16'h0000, 7'h00},
    // 13 bits, window bounds and wrapped widths mixed in
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h0578, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h0190, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'hfda7, 16'h0258, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'hfed3, 16'h012c, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h0320, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0000, 16'h03e8, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h0064, 16'h0578, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h2328, 16'h2580, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h8000, 16'h84b0, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h7fff, 16'h8257, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h4e20, 16'h52d0, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'h9c40, 16'ha08c, 1'b0, 16'h0000, 7'h00},
    '{1'b0, irpw_pkg::REG_RECEIVE_ENABLE, 16'h0000, 16'hea60, 16'hed1c, 1'b1, 16'h14d6, 7'h53}
  };

  function automatic bit in_window(input irpw_pkg::time_us_t w,
                                   input irpw_pkg::time_us_t lo,
                                   input irpw_pkg::time_us_t hi);
    return (w >= lo) && (w <= hi);
  endfunction

  // Decodes one mark against the shadow registers; returns 1 with the
  // finished packet when the last bit lands.
  function automatic bit decode_mark(input irpw_pkg::time_us_t fall_t,
                                     input irpw_pkg::time_us_t rise_t,
                                     output packet_t pkt);
    irpw_pkg::time_us_t width;
    bit                 is_one;
    pkt = '0;
    if (!shadow_cfg.receive_enable) return 1'b0;
    // timer wrap: the width counts from fall up to the timer max, then rise
    width = (rise_t >= fall_t) ? irpw_pkg::time_us_t'(rise_t - fall_t)
                               : irpw_pkg::time_us_t'(TIMER_MAX - fall_t + rise_t);
    if (in_window(width, shadow_cfg.header_min_us, shadow_cfg.header_max_us)) begin
      rx_word  = '0;
      rx_count = irpw_pkg::COUNT_W'(1);
      return 1'b0;
    end
    if (rx_count == 0 || rx_count > irpw_pkg::PACKET_BITS) return 1'b0;
    is_one = in_window(width, shadow_cfg.one_min_us, shadow_cfg.one_max_us);
    if (!is_one && !in_window(width, shadow_cfg.zero_min_us, shadow_cfg.zero_max_us)) begin
      rx_word  = '0;
      rx_count = '0;
      return 1'b0;
    end
    rx_word  = {rx_word[irpw_pkg::WORD_W-2:0], is_one};
    rx_count = rx_count + 1'b1;
    if (rx_count == irpw_pkg::PACKET_BITS + 1) begin
      pkt.word = rx_word;
      pkt.id   = rx_word[irpw_pkg::ID_LSB +: irpw_pkg::ID_W];
      rx_word  = '0;
      rx_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string what, input logic [irpw_pkg::WORD_W-1:0] want,
                               input logic [irpw_pkg::WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
  endtask

  // Everything is sampled at the rising edge: register writes update the
  // shadow, accepted capture requests feed the decoder, packet requests are
  // checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    packet_t pkt;
    packet_t want;
    bit      has_pkt;
    if (rst) begin
      shadow_cfg = '{receive_enable: 1'b0,
                     header_min_us:  irpw_pkg::HEADER_MIN_RST,
                     header_max_us:  irpw_pkg::HEADER_MAX_RST,
                     one_min_us:     irpw_pkg::ONE_MIN_RST,
                     one_max_us:     irpw_pkg::ONE_MAX_RST,
                     zero_min_us:    irpw_pkg::ZERO_MIN_RST,
                     zero_max_us:    irpw_pkg::ZERO_MAX_RST};
      rx_word  = '0;
      rx_count = '0;
    end else begin
      if (cfg_write_enable) begin
        case (irpw_pkg::cfg_reg_t'(cfg_index))
          irpw_pkg::REG_RECEIVE_ENABLE: shadow_cfg.receive_enable = cfg_data[0];
          irpw_pkg::REG_HEADER_MIN:     shadow_cfg.header_min_us  = cfg_data;
          irpw_pkg::REG_HEADER_MAX:     shadow_cfg.header_max_us  = cfg_data;
          irpw_pkg::REG_ONE_MIN:        shadow_cfg.one_min_us     = cfg_data;
          irpw_pkg::REG_ONE_MAX:        shadow_cfg.one_max_us     = cfg_data;
          irpw_pkg::REG_ZERO_MIN:       shadow_cfg.zero_min_us    = cfg_data;
          irpw_pkg::REG_ZERO_MAX:       shadow_cfg.zero_max_us    = cfg_data;
          default: ;
        endcase
      end
      if (pkt_if.valid && pkt_if.ready) begin
        if (expected_packets.size() == 0) begin
          note_mismatch("packet with none pending, packet_word", '0, pkt_if.packet_word);
        end else begin
          want = expected_packets.pop_front();
          if (pkt_if.packet_word !== want.word)
            note_mismatch("packet_word", want.word, pkt_if.packet_word);
          if (pkt_if.sender_id !== want.id)
            note_mismatch("sender_id", irpw_pkg::WORD_W'(want.id),
                          irpw_pkg::WORD_W'(pkt_if.sender_id));
        end
      end
      if (cap_if.valid && cap_if.ready) begin
        has_pkt = decode_mark(cap_if.fall_time, cap_if.rise_time, pkt);
        // typed-in rows win over the decoder
        if (pin_valid) begin
          has_pkt = 1'b1;
          pkt     = pin_packet;
        end
        if (has_pkt) expected_packets.push_back(pkt);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Packet side ready: random stalls, or a long hold-off on request while
  // the sender keeps pushing, so the capture side backs up.
  always @(negedge clk) begin
    if (holds_taken != hold_requests) begin
      holds_taken = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      pkt_if.ready = 1'b0;
      hold_left--;
    end else begin
      pkt_if.ready = ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Offers one capture request at a falling edge and holds it until taken.
  task automatic send_mark(input irpw_pkg::time_us_t fall_t, input irpw_pkg::time_us_t rise_t,
                           input bit pin, input packet_t pkt);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      cap_if.valid = 1'b0;
      @(negedge clk);
    end
    cap_if.valid     = 1'b1;
    cap_if.fall_time = fall_t;
    cap_if.rise_time = rise_t;
    pin_valid        = pin;
    pin_packet       = pkt;
    @(posedge clk);
    while (!cap_if.ready) @(posedge clk);
    marks_sent++;
    @(negedge clk);
  endtask

  // Width inside [lo, hi], leaning on the bounds; anything for an empty window.
  function automatic irpw_pkg::time_us_t pick_width(input irpw_pkg::time_us_t lo,
                                                    input irpw_pkg::time_us_t hi);
    int unsigned r;
    r = $urandom_range(9, 0);
    if (lo > hi) return irpw_pkg::time_us_t'($urandom);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return irpw_pkg::time_us_t'($urandom_range(hi, lo));
  endfunction

  task automatic send_kind(input mark_kind_t kind);
    irpw_pkg::time_us_t          w;
    irpw_pkg::time_us_t          fall_t;
    irpw_pkg::time_us_t          rise_t;
    logic [irpw_pkg::TIME_W:0]   sum;
    case (kind)
      MK_HEADER: w = pick_width(shadow_cfg.header_min_us, shadow_cfg.header_max_us);
      MK_ONE:    w = pick_width(shadow_cfg.one_min_us, shadow_cfg.one_max_us);
      MK_ZERO:   w = pick_width(shadow_cfg.zero_min_us, shadow_cfg.zero_max_us);
      default:   w = '0;
    endcase
    if (kind == MK_NOISE) begin
      fall_t = irpw_pkg::time_us_t'($urandom);
      rise_t = irpw_pkg::time_us_t'($urandom);
    end else begin
      // full-scale width only fits without wrap
      fall_t = (w == TIMER_MAX) ? '0 : irpw_pkg::time_us_t'($urandom);
      sum    = fall_t + w;
      // wrapped marks lose one count to the timer max, so step rise by one
      rise_t = sum[irpw_pkg::TIME_W] ? irpw_pkg::time_us_t'(sum + 1'b1)
                                     : sum[irpw_pkg::TIME_W-1:0];
    end
    send_mark(fall_t, rise_t, 1'b0, '0);
  endtask

  // Header plus the packet bits; now and then noise breaks it or a second
  // header restarts it.
  task automatic send_packet();
    int          b;
    int unsigned r;
    send_kind(MK_HEADER);
    for (b = 0; b < irpw_pkg::PACKET_BITS; b++) begin
      r = $urandom_range(99, 0);
      if (r < 3) begin
        send_kind(MK_NOISE);
        break;
      end
      if (r < 6) begin
        send_kind(MK_HEADER);
        b = -1;
        continue;
      end
      send_kind($urandom_range(1, 0) ? MK_ONE : MK_ZERO);
    end
  endtask

  // Register writes only once every packet is out and the pipe has drained.
  task automatic wait_idle();
    cap_if.valid = 1'b0;
    while (expected_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input irpw_pkg::cfg_reg_t idx, input irpw_pkg::time_us_t val);
    cfg_write_enable = 1'b1;
    cfg_index        = idx;
    cfg_data         = val;
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  task automatic apply_setting(input setting_t s);
    logic               enable;
    irpw_pkg::time_us_t hmin, hmax, omin, omax, zmin, zmax;
    enable = 1'b1;
    hmin   = irpw_pkg::HEADER_MIN_RST;
    hmax   = irpw_pkg::HEADER_MAX_RST;
    omin   = irpw_pkg::ONE_MIN_RST;
    omax   = irpw_pkg::ONE_MAX_RST;
    zmin   = irpw_pkg::ZERO_MIN_RST;
    zmax   = irpw_pkg::ZERO_MAX_RST;
    case (s)
      SET_RANDOM: begin
        // windows may overlap; header wins, then one
        zmin = irpw_pkg::time_us_t'($urandom_range(3000, 0));
        zmax = irpw_pkg::time_us_t'(zmin + $urandom_range(2000, 0));
        omin = irpw_pkg::time_us_t'($urandom_range(8000, 0));
        omax = irpw_pkg::time_us_t'(omin + $urandom_range(3000, 0));
        hmin = irpw_pkg::time_us_t'($urandom_range(60000, 0));
        hmax = irpw_pkg::time_us_t'(hmin + $urandom_range(5000, 0));
      end
      SET_EXTREME: begin
        hmin = 16'd5000;
        hmax = 16'd5000;
        omin = TIMER_MAX;
        omax = TIMER_MAX;
        zmin = '0;
        zmax = '0;
      end
      SET_EMPTY_ZERO: begin
        // min above max: every zero aborts
        zmin = irpw_pkg::ZERO_MAX_RST;
        zmax = irpw_pkg::ZERO_MIN_RST;
      end
      SET_ALL_HEADER: begin
        hmin = '0;
        hmax = TIMER_MAX;
      end
      SET_DISABLED: enable = 1'b0;
      default: ;
    endcase
    wait_idle();
    write_reg(irpw_pkg::REG_RECEIVE_ENABLE, irpw_pkg::time_us_t'(enable));
    write_reg(irpw_pkg::REG_HEADER_MIN, hmin);
    write_reg(irpw_pkg::REG_HEADER_MAX, hmax);
    write_reg(irpw_pkg::REG_ONE_MIN, omin);
    write_reg(irpw_pkg::REG_ONE_MAX, omax);
    write_reg(irpw_pkg::REG_ZERO_MIN, zmin);
    write_reg(irpw_pkg::REG_ZERO_MAX, zmax);
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned n_marks;
    setting_t    s;
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index        = irpw_pkg::REG_RECEIVE_ENABLE;
    cfg_data         = '0;
    cap_if.valid     = 1'b0;
    cap_if.fall_time = '0;
    cap_if.rise_time = '0;
    pkt_if.ready     = 1'b0;
    pin_valid        = 1'b0;
    pin_packet       = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_mark(dir_rows[i].fall_t, dir_rows[i].rise_t, dir_rows[i].pinned,
                  '{word: dir_rows[i].word, id: dir_rows[i].id});
      end
    end

    // random part: three idle patterns, each walking every setting
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin tx_idle_pct = 6;  rx_idle_pct = 48; end
        1:       begin tx_idle_pct = 48; rx_idle_pct = 6;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
        s = setting_t'((ph + mode) % NUM_SETTINGS);
        apply_setting(s);
        // one long hold-off while the sender runs flat out
        if (mode == 2 && ph == 0) hold_requests++;
        n_marks = (s == SET_ALL_HEADER || s == SET_DISABLED) ? SHORT_MARKS : PHASE_MARKS;
        phase_start = marks_sent;
        while (marks_sent - phase_start < n_marks) begin
          if ($urandom_range(99, 0) < 85) send_packet();
          else send_kind(MK_NOISE);
        end
      end
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_packets.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
